// File: design/dbm_pkg.sv
// Shared types and constants for the doorbell mailbox register block.
`timescale 1ns / 1ps
package dbm_pkg;

	localparam int          CH_W     = 3;
	localparam logic [11:0] BANK1_BASE   = 12'h100;
	localparam logic [11:0] OFF_REVISION = 12'h0F0;
	localparam logic [11:0] OFF_NCHAN    = 12'h0F4;
	localparam logic [11:0] OFF_NBANKS   = 12'h0F8;
	localparam logic [4:0]  REG_STAT     = 5'h00;
	localparam logic [4:0]  REG_SET      = 5'h04;
	localparam logic [4:0]  REG_CLEAR    = 5'h08;
	localparam logic [4:0]  REG_MSTAT    = 5'h0C;
	localparam logic [4:0]  REG_MSET     = 5'h10;
	localparam logic [4:0]  REG_MCLEAR   = 5'h14;
	localparam logic [31:0] REVISION_VALUE = 32'h0000_0100;
	localparam logic [31:0] NUM_BANKS      = 32'd2;
	localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OUTSIDE  = 3'd1;
	localparam logic [2:0] ST_READ_WO  = 3'd2;
	localparam logic [2:0] ST_WRITE_RO = 3'd3;
	localparam logic [2:0] ST_RESERVED = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET,
		OP_CLR,
		OP_MSET,
		OP_MCLR
	} op_t;

	typedef enum logic [2:0] {
		RD_ZERO,
		RD_REV,
		RD_NCHAN,
		RD_NBANKS,
		RD_STAT,
		RD_MASK
	} rsel_t;

	typedef struct packed {
		logic [2:0]      st;
		op_t             op;
		rsel_t           rsel;
		logic            bank;
		logic [CH_W-1:0] ch;
	} dec_t;

endpackage

// File: design/doorbell_mailbox_regs.sv
// Two-bank doorbell mailbox register block.
// An accepted access has its result registered in the output register.
// Throughput: one access per cycle, each a read-modify-write of at most one channel word;
// the input stalls only while a held result is not taken.
// Reset: status words clear to zero, mask words to all ones, no result pending.
`timescale 1ns / 1ps
module doorbell_mailbox_regs import dbm_pkg::*; #(
	parameter int CHANNELS_PER_BANK = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [11:0] addr,
	input  logic [31:0] wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] rdata,
	output logic [2:0]  status,
	output logic        irq_bank0,
	output logic        irq_bank1
);

	dec_t        dec;
	logic        acc;
	logic [31:0] rd_stat;
	logic [31:0] rd_mask;
	logic        irq0_nxt;
	logic        irq1_nxt;
	logic [31:0] rdata_d;
	logic        valid_q;
	logic [31:0] rdata_q;
	logic [2:0]  status_q;
	logic        irq0_q;
	logic        irq1_q;

	assign in_stall = valid_q && out_stall;
	assign acc      = in_valid && !in_stall;

	dbm_decode #(
		.CHANNELS_PER_BANK(CHANNELS_PER_BANK)
	) u_decode (
		.req_type(req_type),
		.addr    (addr),
		.dec     (dec)
	);

	dbm_regfile #(
		.CHANNELS_PER_BANK(CHANNELS_PER_BANK)
	) u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (acc),
		.dec     (dec),
		.wdata   (wdata),
		.rd_stat (rd_stat),
		.rd_mask (rd_mask),
		.irq0_nxt(irq0_nxt),
		.irq1_nxt(irq1_nxt)
	);

	always_comb begin
		case (dec.rsel)
			RD_REV:    rdata_d = REVISION_VALUE;
			RD_NCHAN:  rdata_d = 32'(CHANNELS_PER_BANK);
			RD_NBANKS: rdata_d = NUM_BANKS;
			RD_STAT:   rdata_d = rd_stat;
			RD_MASK:   rdata_d = rd_mask;
			default:   rdata_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (acc) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// hold the result while the output side stalls
	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_q  <= rdata_d;
			status_q <= dec.st;
			irq0_q   <= irq0_nxt;
			irq1_q   <= irq1_nxt;
		end
	end

	assign out_valid = valid_q;
	assign rdata     = rdata_q;
	assign status    = status_q;
	assign irq_bank0 = irq0_q;
	assign irq_bank1 = irq1_q;

endmodule

// File: design/dbm_decode.sv
// Address decoder: maps one bus access to a status code, an update and a read source.
`timescale 1ns / 1ps
module dbm_decode import dbm_pkg::*; #(
	parameter int CHANNELS_PER_BANK = 3
) (
	input  logic        req_type,
	input  logic [11:0] addr,
	output dec_t        dec
);

	localparam logic [11:0] BANK_SPAN = 12'(CHANNELS_PER_BANK * 32);

	logic in_b0;
	logic in_b1;
	logic is_write;

	assign is_write = req_type;
	assign in_b0    = addr < BANK_SPAN;
	assign in_b1    = (addr >= BANK1_BASE) && (addr < BANK1_BASE + BANK_SPAN);

	always_comb begin
		dec.st   = ST_OK;
		dec.op   = OP_NONE;
		dec.rsel = RD_ZERO;
		dec.bank = in_b1;
		dec.ch   = addr[7:5];
		if (addr == OFF_REVISION || addr == OFF_NCHAN || addr == OFF_NBANKS) begin
			if (is_write) begin
				dec.st = ST_WRITE_RO;
			end else if (addr == OFF_REVISION) begin
				dec.rsel = RD_REV;
			end else if (addr == OFF_NCHAN) begin
				dec.rsel = RD_NCHAN;
			end else begin
				dec.rsel = RD_NBANKS;
			end
		end else if (!in_b0 && !in_b1) begin
			dec.st = ST_OUTSIDE;
		end else begin
			// bank bases sit on the channel stride, so the low five bits are the register
			case (addr[4:0])
				REG_STAT, REG_MSTAT: begin
					if (is_write) begin
						dec.st = ST_WRITE_RO;
					end else begin
						dec.rsel = (addr[4:0] == REG_STAT) ? RD_STAT : RD_MASK;
					end
				end
				REG_SET, REG_CLEAR, REG_MSET, REG_MCLEAR: begin
					if (!is_write) begin
						dec.st = ST_READ_WO;
					end else begin
						case (addr[4:0])
							REG_SET:   dec.op = OP_SET;
							REG_CLEAR: dec.op = OP_CLR;
							REG_MSET:  dec.op = OP_MSET;
							default:   dec.op = OP_MCLR;
						endcase
					end
				end
				default: begin
					dec.st = ST_RESERVED;
				end
			endcase
		end
	end

endmodule

// File: design/dbm_regfile.sv
// Channel status and mask words with set/clear update and per-bank interrupt levels.
`timescale 1ns / 1ps
module dbm_regfile import dbm_pkg::*; #(
	parameter int CHANNELS_PER_BANK = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  dec_t        dec,
	input  logic [31:0] wdata,
	output logic [31:0] rd_stat,
	output logic [31:0] rd_mask,
	output logic        irq0_nxt,
	output logic        irq1_nxt
);

	localparam int NE = 2 * CHANNELS_PER_BANK;

	logic [31:0]   stat_q [NE];
	logic [31:0]   mask_q [NE];
	logic [31:0]   stat_d [NE];
	logic [31:0]   mask_d [NE];
	logic [NE-1:0] hit;
	logic [31:0]   pend0;
	logic [31:0]   pend1;

	for (genvar e = 0; e < NE; e++) begin : g_hit
		localparam int EB = e / CHANNELS_PER_BANK;
		localparam int EC = e % CHANNELS_PER_BANK;
		assign hit[e] = (dec.bank == 1'(EB)) && (dec.ch == CH_W'(EC));
	end

	always_comb begin
		rd_stat = '0;
		rd_mask = '0;
		pend0   = '0;
		pend1   = '0;
		for (int e = 0; e < NE; e++) begin
			stat_d[e] = stat_q[e];
			mask_d[e] = mask_q[e];
			if (we && hit[e]) begin
				case (dec.op)
					OP_SET:  stat_d[e] = stat_q[e] | wdata;
					OP_CLR:  stat_d[e] = stat_q[e] & ~wdata;
					OP_MSET: mask_d[e] = mask_q[e] | wdata;
					OP_MCLR: mask_d[e] = mask_q[e] & ~wdata;
					default: ;
				endcase
			end
			if (hit[e]) begin
				rd_stat = rd_stat | stat_q[e];
				rd_mask = rd_mask | mask_q[e];
			end
			// levels follow the updated words
			if (e < CHANNELS_PER_BANK) begin
				pend0 = pend0 | (stat_d[e] & ~mask_d[e]);
			end else begin
				pend1 = pend1 | (stat_d[e] & ~mask_d[e]);
			end
		end
	end

	assign irq0_nxt = |pend0;
	assign irq1_nxt = |pend1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < NE; e++) begin
				stat_q[e] <= '0;
				mask_q[e] <= ALL_ONES;
			end
		end else if (we) begin
			for (int e = 0; e < NE; e++) begin
				stat_q[e] <= stat_d[e];
				mask_q[e] <= mask_d[e];
			end
		end
	end

endmodule
